### hdl/brs_pkg.sv
// Package for the rectangle segmentation block: sizes, payload structs,
// sequencer states and shared-unit request types. No dependencies.
package brs_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int STRIDE     = MAX_WIDTH + 1;
   localparam int DEPTH      = STRIDE * (MAX_HEIGHT + 1);
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int DIM_W      = 7;
   localparam int POS_W      = 6;
   localparam int COLOR_W    = 16;
   localparam int SUM_W      = 28;
   localparam int PIX_W      = 3 * SUM_W;
   localparam int CNT_W      = 13;
   localparam int QW         = 58;
   localparam int STEP_W     = 6;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_data_type;

   typedef struct packed {
      logic [POS_W-1:0]   top_row;
      logic [POS_W-1:0]   left_col;
      logic [DIM_W-1:0]   bottom_row;
      logic [DIM_W-1:0]   right_col;
      logic [COLOR_W-1:0] inner_red;
      logic [COLOR_W-1:0] inner_green;
      logic [COLOR_W-1:0] inner_blue;
      logic [COLOR_W-1:0] outer_red;
      logic [COLOR_W-1:0] outer_green;
      logic [COLOR_W-1:0] outer_blue;
   } rsp_data_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic            start;
      alu_op_type      op;
      logic [QW-1:0]   a;
      logic [SUM_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic          busy;
      logic          done;
      logic [QW-1:0] result;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_LWRITE,
      ST_TOTAL,
      ST_TOTAL_WAIT,
      ST_CAND,
      ST_FIN,
      ST_READ,
      ST_MUL,
      ST_DIV_IN,
      ST_DIV_OUT,
      ST_SCORE,
      ST_MEAN,
      ST_OUT
   } state_type;

   function automatic logic [ADDR_W-1:0] table_addr(input logic [DIM_W-1:0] row,
                                                    input logic [DIM_W-1:0] col);
      table_addr = ADDR_W'(row) * ADDR_W'(STRIDE) + ADDR_W'(col);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      clamp_dim = r;
   endfunction

endpackage

### hdl/brs_ram.sv
// Summed-area table storage: one word holds the red, green and blue sums.
// One write port, one registered read port. Depends on brs_pkg.
module brs_ram import brs_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PIX_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/brs_alu.sv
// Shared bit-serial unit: shift-add multiply and restoring divide,
// one bit per cycle. Depends on brs_pkg.
module brs_alu import brs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   alu_op_type        op_ff, op_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [QW-1:0]     acc_ff, acc_in;
   logic [QW-1:0]     shf_ff, shf_in;
   logic [SUM_W-1:0]  mpl_ff, mpl_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W:0]    rem_sh;
   logic [STEP_W-1:0] last;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      shf_in  = shf_ff;
      mpl_in  = mpl_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff[CNT_W-1:0], shf_ff[QW-1]};
      last    = (op_ff == ALU_MUL) ? STEP_W'(SUM_W - 1) : STEP_W'(QW - 1);
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = '0;
         acc_in  = '0;
         rem_in  = '0;
         shf_in  = req.a;
         mpl_in  = req.b;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               if (mpl_ff[0]) begin
                  acc_in = acc_ff + shf_ff;
               end
               shf_in = {shf_ff[QW-2:0], 1'b0};
               mpl_in = {1'b0, mpl_ff[SUM_W-1:1]};
            end
            ALU_DIV: begin
               if (rem_sh >= {1'b0, mpl_ff[CNT_W-1:0]}) begin
                  rem_in = rem_sh - {1'b0, mpl_ff[CNT_W-1:0]};
                  acc_in = {acc_ff[QW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  acc_in = {acc_ff[QW-2:0], 1'b0};
               end
               shf_in = {shf_ff[QW-2:0], 1'b0};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      shf_ff <= shf_in;
      mpl_ff <= mpl_in;
      rem_ff <= rem_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

### hdl/best_rectangle_segmentation.sv
// Best two-region rectangle segmentation over a summed-area table.
// Sequencer and datapath; uses brs_pkg, brs_ram and brs_alu.
//
// Usage: set image_width (index 0) and image_height (index 1) on the csr_
// port while idle; any write restarts loading. Pixels then arrive on req_
// in row-major order, red/green/blue unsigned Q1.15. A pixel takes a table
// read of the row above in ST_LOAD, then a table write in ST_LWRITE through
// the one memory port pair. After the last pixel the search runs and
// req_stall stays high until the result is taken on rsp_.
// Search: the image total is read first, then each candidate rectangle
// takes its corner reads, 6 squarings and 2 divides on the single
// bit-serial multiply/divide unit; the candidate count is sum over sizes
// of (h-hh+1)*(w-ww+1), less the whole image. The final means add the
// corner reads of the best rectangle and up to 6 divides.
// One result per image; it is held in the output register while rsp_stall
// is high, and loading resumes once it is taken.
// Reset: 1x1 image, loading at row 0, column 0. No clearing pass: reads of
// the zero border row and column are forced to zero by address.
module best_rectangle_segmentation import brs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   state_type state_ff, state_in;
   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [SUM_W-1:0] racc_ff [3];
   logic [SUM_W-1:0] racc_in [3];
   logic             border_ff, border_in;
   logic [DIM_W-1:0] hh_ff, hh_in, ww_ff, ww_in, y0_ff, y0_in, x0_ff, x0_in;
   logic [SUM_W-1:0] total_ff [3];
   logic [SUM_W-1:0] total_in [3];
   logic [SUM_W-1:0] sum_ff [3];
   logic [SUM_W-1:0] sum_in [3];
   logic [2:0]       corner_ff, corner_in;
   logic [2:0]       op_ff, op_in;
   logic             launched_ff, launched_in;
   logic [CNT_W-1:0] nall_ff, nall_in, nin_ff, nin_in, nout_ff, nout_in;
   logic [QW-1:0]    qi_ff, qi_in, qo_ff, qo_in, qdi_ff, qdi_in, qdo_ff, qdo_in;
   logic             found_ff, found_in;
   logic [QW:0]      best_ff, best_in;
   logic [DIM_W-1:0] by0_ff, by0_in, bx0_ff, bx0_in, by1_ff, by1_in, bx1_ff, bx1_in;
   logic             final_ff, final_in;
   logic [COLOR_W-1:0] mean_ff [6];
   logic [COLOR_W-1:0] mean_in [6];
   logic             rsp_valid_ff, rsp_valid_in;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic              ld_restart;
   logic [POS_W-1:0]  ld_col, ld_row;
   logic [DIM_W-1:0]  ry0, ry1, rx0, rx1, cr_row, cr_col;
   logic [SUM_W-1:0]  rd_val [3];
   logic [SUM_W-1:0]  opnd;
   logic [1:0]        ch;
   logic [QW:0]       score;
   logic [2*DIM_W-1:0] area;
   logic              accept;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PIX_W-1:0]  wr_data, rd_data;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   brs_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brs_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_comb begin
      w_eff  = clamp_dim(width_ff, DIM_W'(MAX_WIDTH));
      h_eff  = clamp_dim(height_ff, DIM_W'(MAX_HEIGHT));
      accept = req_valid && (state_ff == ST_LOAD);
      ld_restart = ({1'b0, col_ff} >= w_eff) || ({1'b0, row_ff} >= h_eff);
      ld_col = ld_restart ? '0 : col_ff;
      ld_row = ld_restart ? '0 : row_ff;
      ry0 = final_ff ? by0_ff : y0_ff;
      ry1 = final_ff ? by1_ff : y0_ff + hh_ff;
      rx0 = final_ff ? bx0_ff : x0_ff;
      rx1 = final_ff ? bx1_ff : x0_ff + ww_ff;
      unique case (corner_ff[1:0])
         2'd0: begin cr_row = ry1; cr_col = rx1; end
         2'd1: begin cr_row = ry0; cr_col = rx1; end
         2'd2: begin cr_row = ry1; cr_col = rx0; end
         default: begin cr_row = ry0; cr_col = rx0; end
      endcase
      for (int i = 0; i < 3; i++) begin
         rd_val[i] = border_ff ? '0 : rd_data[(3-i)*SUM_W-1 -: SUM_W];
      end
      ch   = (op_ff < 3'd3) ? op_ff[1:0] : 2'(op_ff - 3'd3);
      opnd = (op_ff < 3'd3) ? sum_ff[ch] : total_ff[ch] - sum_ff[ch];
      score = {1'b0, qdi_ff} + {1'b0, qdo_ff};
      area  = '0;

      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      racc_in      = racc_ff;
      border_in    = border_ff;
      hh_in        = hh_ff;
      ww_in        = ww_ff;
      y0_in        = y0_ff;
      x0_in        = x0_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      corner_in    = corner_ff;
      op_in        = op_ff;
      launched_in  = launched_ff;
      nall_in      = nall_ff;
      nin_in       = nin_ff;
      nout_in      = nout_ff;
      qi_in        = qi_ff;
      qo_in        = qo_ff;
      qdi_in       = qdi_ff;
      qdo_in       = qdo_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      by0_in       = by0_ff;
      bx0_in       = bx0_ff;
      by1_in       = by1_ff;
      bx1_in       = bx1_ff;
      final_in     = final_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff;

      wr_en   = 1'b0;
      wr_addr = table_addr({1'b0, row_ff} + DIM_W'(1), {1'b0, col_ff} + DIM_W'(1));
      wr_data = '0;
      rd_addr = table_addr(cr_row, cr_col);
      alu_req = '0;

      unique case (state_ff)
         ST_LOAD: begin
            rd_addr = table_addr({1'b0, ld_row}, {1'b0, ld_col} + DIM_W'(1));
            if (accept) begin
               racc_in[0] = ((ld_col == '0) ? '0 : racc_ff[0]) + SUM_W'(req_data.red);
               racc_in[1] = ((ld_col == '0) ? '0 : racc_ff[1]) + SUM_W'(req_data.green);
               racc_in[2] = ((ld_col == '0) ? '0 : racc_ff[2]) + SUM_W'(req_data.blue);
               col_in    = ld_col;
               row_in    = ld_row;
               border_in = (ld_row == '0);
               state_in  = ST_LWRITE;
            end
         end
         ST_LWRITE: begin
            wr_en   = 1'b1;
            wr_data = {rd_val[0] + racc_ff[0], rd_val[1] + racc_ff[1],
                       rd_val[2] + racc_ff[2]};
            state_in = ST_LOAD;
            if ({1'b0, col_ff} + DIM_W'(1) == w_eff) begin
               col_in = '0;
               if ({1'b0, row_ff} + DIM_W'(1) == h_eff) begin
                  row_in   = '0;
                  state_in = ST_TOTAL;
               end else begin
                  row_in = row_ff + POS_W'(1);
               end
            end else begin
               col_in = col_ff + POS_W'(1);
            end
         end
         ST_TOTAL: begin
            rd_addr   = table_addr(h_eff, w_eff);
            border_in = 1'b0;
            state_in  = ST_TOTAL_WAIT;
         end
         ST_TOTAL_WAIT: begin
            total_in = rd_val;
            area     = h_eff * w_eff;
            nall_in  = area[CNT_W-1:0];
            found_in = 1'b0;
            best_in  = '0;
            by0_in   = '0;
            bx0_in   = '0;
            by1_in   = h_eff;
            bx1_in   = w_eff;
            hh_in    = DIM_W'(1);
            ww_in    = DIM_W'(1);
            y0_in    = '0;
            x0_in    = '0;
            final_in = 1'b0;
            state_in = ST_CAND;
         end
         ST_CAND: begin
            if (hh_ff == h_eff && ww_ff == w_eff) begin
               final_in = 1'b1;
               state_in = ST_FIN;
            end else begin
               area      = hh_ff * ww_ff;
               nin_in    = area[CNT_W-1:0];
               nout_in   = nall_ff - area[CNT_W-1:0];
               corner_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_FIN: begin
            area      = (by1_ff - by0_ff) * (bx1_ff - bx0_ff);
            nin_in    = area[CNT_W-1:0];
            nout_in   = nall_ff - area[CNT_W-1:0];
            corner_in = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            border_in = (cr_row == '0) || (cr_col == '0);
            corner_in = corner_ff + 3'd1;
            if (corner_ff == 3'd1) begin
               sum_in = rd_val;
            end else if (corner_ff == 3'd2 || corner_ff == 3'd3) begin
               for (int i = 0; i < 3; i++) begin
                  sum_in[i] = sum_ff[i] - rd_val[i];
               end
            end else if (corner_ff == 3'd4) begin
               for (int i = 0; i < 3; i++) begin
                  sum_in[i] = sum_ff[i] + rd_val[i];
               end
               corner_in   = '0;
               op_in       = '0;
               launched_in = 1'b0;
               qi_in       = '0;
               qo_in       = '0;
               state_in    = final_ff ? ST_MEAN : ST_MUL;
            end
         end
         ST_MUL: begin
            if (!launched_ff) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_MUL;
               alu_req.a     = QW'(opnd);
               alu_req.b     = opnd;
               launched_in   = 1'b1;
            end else if (alu_rsp.done) begin
               launched_in = 1'b0;
               if (op_ff < 3'd3) begin
                  qi_in = qi_ff + alu_rsp.result;
               end else begin
                  qo_in = qo_ff + alu_rsp.result;
               end
               if (op_ff == 3'd5) begin
                  op_in    = '0;
                  state_in = ST_DIV_IN;
               end else begin
                  op_in = op_ff + 3'd1;
               end
            end
         end
         ST_DIV_IN: begin
            if (!launched_ff) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = qi_ff;
               alu_req.b     = SUM_W'(nin_ff);
               launched_in   = 1'b1;
            end else if (alu_rsp.done) begin
               launched_in = 1'b0;
               qdi_in      = alu_rsp.result;
               state_in    = ST_DIV_OUT;
            end
         end
         ST_DIV_OUT: begin
            if (!launched_ff) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = qo_ff;
               alu_req.b     = SUM_W'(nout_ff);
               launched_in   = 1'b1;
            end else if (alu_rsp.done) begin
               launched_in = 1'b0;
               qdo_in      = alu_rsp.result;
               state_in    = ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (!found_ff || score > best_ff) begin
               found_in = 1'b1;
               best_in  = score;
               by0_in   = y0_ff;
               bx0_in   = x0_ff;
               by1_in   = y0_ff + hh_ff;
               bx1_in   = x0_ff + ww_ff;
            end
            if (x0_ff + ww_ff < w_eff) begin
               x0_in = x0_ff + DIM_W'(1);
            end else begin
               x0_in = '0;
               if (y0_ff + hh_ff < h_eff) begin
                  y0_in = y0_ff + DIM_W'(1);
               end else begin
                  y0_in = '0;
                  if (ww_ff < w_eff) begin
                     ww_in = ww_ff + DIM_W'(1);
                  end else begin
                     ww_in = DIM_W'(1);
                     hh_in = hh_ff + DIM_W'(1);
                  end
               end
            end
            state_in = ST_CAND;
         end
         ST_MEAN: begin
            if (op_ff >= 3'd3 && nout_ff == '0) begin
               mean_in[op_ff] = '0;
               if (op_ff == 3'd5) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  op_in = op_ff + 3'd1;
               end
            end else if (!launched_ff) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = QW'(opnd);
               alu_req.b     = (op_ff < 3'd3) ? SUM_W'(nin_ff) : SUM_W'(nout_ff);
               launched_in   = 1'b1;
            end else if (alu_rsp.done) begin
               launched_in    = 1'b0;
               mean_in[op_ff] = alu_rsp.result[COLOR_W-1:0];
               if (op_ff == 3'd5) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  op_in = op_ff + 3'd1;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         launched_ff  <= 1'b0;
         found_ff     <= 1'b0;
         final_ff     <= 1'b0;
         corner_ff    <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         launched_ff  <= launched_in;
         found_ff     <= found_in;
         final_ff     <= final_in;
         corner_ff    <= corner_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      racc_ff   <= racc_in;
      border_ff <= border_in;
      hh_ff     <= hh_in;
      ww_ff     <= ww_in;
      y0_ff     <= y0_in;
      x0_ff     <= x0_in;
      total_ff  <= total_in;
      sum_ff    <= sum_in;
      nall_ff   <= nall_in;
      nin_ff    <= nin_in;
      nout_ff   <= nout_in;
      qi_ff     <= qi_in;
      qo_ff     <= qo_in;
      qdi_ff    <= qdi_in;
      qdo_ff    <= qdo_in;
      best_ff   <= best_in;
      by0_ff    <= by0_in;
      bx0_ff    <= bx0_in;
      by1_ff    <= by1_in;
      bx1_ff    <= bx1_in;
      mean_ff   <= mean_in;
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.top_row     = by0_ff[POS_W-1:0];
      rsp_data.left_col    = bx0_ff[POS_W-1:0];
      rsp_data.bottom_row  = by1_ff;
      rsp_data.right_col   = bx1_ff;
      rsp_data.inner_red   = mean_ff[0];
      rsp_data.inner_green = mean_ff[1];
      rsp_data.inner_blue  = mean_ff[2];
      rsp_data.outer_red   = mean_ff[3];
      rsp_data.outer_green = mean_ff[4];
      rsp_data.outer_blue  = mean_ff[5];
   end

   a_stall_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_rows_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bottom_row > {1'b0, rsp_data.top_row}))
      else $error("empty row span in result");

   a_cols_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.right_col > {1'b0, rsp_data.left_col}))
      else $error("empty column span in result");

   a_alu_free: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !alu_rsp.busy)
      else $error("shared unit started while busy");

endmodule
